// ----- hw/rtl/fmf_pkg.sv -----
`default_nettype none
package fmf_pkg;

  // Largest frame the store holds.
  localparam int MAX_WIDTH  = 512;
  localparam int MAX_HEIGHT = 512;

  // Configuration register width and register indexes.
  localparam int CFG_W     = 10;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIRROR_MODE  = 2'd2;

  localparam logic [CFG_W-1:0] RST_FRAME_WIDTH  = 10'd400;
  localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = 10'd500;
  localparam logic             RST_MIRROR_MODE  = 1'b1;

  localparam int PIX_W = 8;

  // Position counters and clamped dimensions.
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int WDIM_W  = $clog2(MAX_WIDTH + 1);
  localparam int HDIM_W  = $clog2(MAX_HEIGHT + 1);
  localparam int WCMP_W  = (CFG_W > WDIM_W) ? CFG_W : WDIM_W;
  localparam int HCMP_W  = (CFG_W > HDIM_W) ? CFG_W : HDIM_W;

  // Frame store address: bank bit, row, column.
  localparam int ADDR_W  = 1 + ROW_W + COL_W;
  localparam int DEPTH   = 2 ** ADDR_W;

  // One cycle's request from the control logic to the frame store.
  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [PIX_W-1:0]  wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              row_last;
    logic              frame_last;
  } fmf_req_t;

endpackage
`default_nettype wire

// ----- hw/rtl/fmf_if.sv -----
`default_nettype none
interface fmf_in_if;
  logic                     valid;
  logic                     ready;
  logic [fmf_pkg::PIX_W-1:0] pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink   (input valid, input pixel_in, output ready);
endinterface

interface fmf_out_if;
  logic                     valid;
  logic                     ready;
  logic [fmf_pkg::PIX_W-1:0] pixel_out;
  logic                     row_last;
  logic                     frame_last;

  modport source (output valid, output pixel_out, output row_last, output frame_last,
                  input ready);
  modport sink   (input valid, input pixel_out, input row_last, input frame_last,
                  output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/frame_mirror_flip.sv -----
`default_nettype none
// Channel     Direction  Payload                          Transfer
// in_stream   sink       pixel_in[7:0]                    valid && ready
// out_stream  source     pixel_out[7:0], row_last,        valid && ready
//                        frame_last
// cfg_*       write      cfg_index[1:0], cfg_data[9:0]    cfg_wr_en
//
// One pixel is taken per clock while in_stream.ready is high; the rate is set by
// the frame store's single write port and single read port, both used once per
// input transfer, the read port only once a whole frame sits in the other bank.
// A mirrored pixel passes the registered store read, then the output register.
// Reset clears the counters, bank select and valid flags at once and loads the
// default configuration; the store is not cleared, so it is ready the cycle after reset.
// A stall on the output side holds the read stage and output register and
// drops in_stream.ready only when both are full.
module frame_mirror_flip (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  fmf_in_if.sink                             in_stream,
  fmf_out_if.source                          out_stream,
  input  wire logic                          cfg_wr_en,
  input  wire logic [fmf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [fmf_pkg::CFG_W-1:0]     cfg_data
);

  fmf_pkg::fmf_req_t req;
  logic              st_ready;
  logic              accept;

  // An input transfer writes the pixel into the current bank and, once a
  // whole frame sits in the other bank, reads its mirrored pixel there.
  assign in_stream.ready = st_ready;
  assign accept          = in_stream.valid && st_ready;

  fmf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .pixel     (in_stream.pixel_in),
    .req       (req)
  );

  fmf_store u_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (req),
    .ready      (st_ready),
    .out_stream (out_stream)
  );

endmodule
`default_nettype wire

// ----- hw/rtl/fmf_ctrl.sv -----
`default_nettype none
module fmf_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [fmf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [fmf_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic                          accept,
  input  wire logic [fmf_pkg::PIX_W-1:0]     pixel,
  output fmf_pkg::fmf_req_t                  req
);

  logic [fmf_pkg::CFG_W-1:0]  frame_width_r;
  logic [fmf_pkg::CFG_W-1:0]  frame_height_r;
  logic                       mirror_mode_r;
  logic                       write_bank_r;
  logic                       prev_ready_r;
  logic [fmf_pkg::ROW_W-1:0]  row_r;
  logic [fmf_pkg::COL_W-1:0]  col_r;

  logic                       write_bank_nxt;
  logic                       prev_ready_nxt;
  logic [fmf_pkg::ROW_W-1:0]  row_nxt;
  logic [fmf_pkg::COL_W-1:0]  col_nxt;

  logic                       cfg_hit;
  logic [fmf_pkg::WCMP_W-1:0] w_cmp;
  logic [fmf_pkg::HCMP_W-1:0] h_cmp;
  logic [fmf_pkg::WDIM_W-1:0] w_eff;
  logic [fmf_pkg::HDIM_W-1:0] h_eff;
  logic [fmf_pkg::COL_W-1:0]  w_last;
  logic [fmf_pkg::ROW_W-1:0]  h_last;
  logic                       end_row;
  logic                       end_frame;
  logic [fmf_pkg::ROW_W-1:0]  rd_row;
  logic [fmf_pkg::COL_W-1:0]  rd_col;

  // A zero dimension counts as one, an oversized one saturates.
  always_comb begin
    w_cmp = fmf_pkg::WCMP_W'(frame_width_r);
    h_cmp = fmf_pkg::HCMP_W'(frame_height_r);
    if (w_cmp == '0) begin
      w_eff = fmf_pkg::WDIM_W'(1);
    end else if (w_cmp > fmf_pkg::WCMP_W'(fmf_pkg::MAX_WIDTH)) begin
      w_eff = fmf_pkg::WDIM_W'(fmf_pkg::MAX_WIDTH);
    end else begin
      w_eff = fmf_pkg::WDIM_W'(w_cmp);
    end
    if (h_cmp == '0) begin
      h_eff = fmf_pkg::HDIM_W'(1);
    end else if (h_cmp > fmf_pkg::HCMP_W'(fmf_pkg::MAX_HEIGHT)) begin
      h_eff = fmf_pkg::HDIM_W'(fmf_pkg::MAX_HEIGHT);
    end else begin
      h_eff = fmf_pkg::HDIM_W'(h_cmp);
    end
  end

  assign w_last    = fmf_pkg::COL_W'(w_eff - fmf_pkg::WDIM_W'(1));
  assign h_last    = fmf_pkg::ROW_W'(h_eff - fmf_pkg::HDIM_W'(1));
  assign end_row   = (col_r == w_last);
  assign end_frame = end_row && (row_r == h_last);

  always_comb begin
    if (mirror_mode_r) begin
      rd_row = h_last - row_r;
      rd_col = col_r;
    end else begin
      rd_row = row_r;
      rd_col = w_last - col_r;
    end
  end

  always_comb begin
    req.wr_en      = accept;
    req.wr_addr    = {write_bank_r, row_r, col_r};
    req.wr_data    = pixel;
    req.rd_en      = accept && prev_ready_r;
    req.rd_addr    = {~write_bank_r, rd_row, rd_col};
    req.row_last   = end_row;
    req.frame_last = end_frame;
  end

  always_comb begin
    unique case (cfg_index)
      fmf_pkg::CFG_FRAME_WIDTH,
      fmf_pkg::CFG_FRAME_HEIGHT,
      fmf_pkg::CFG_MIRROR_MODE: cfg_hit = cfg_wr_en;
      default:                  cfg_hit = 1'b0;
    endcase
  end

  always_comb begin
    write_bank_nxt = write_bank_r;
    prev_ready_nxt = prev_ready_r;
    row_nxt        = row_r;
    col_nxt        = col_r;
    if (cfg_hit) begin
      prev_ready_nxt = 1'b0;
      row_nxt        = '0;
      col_nxt        = '0;
    end else if (accept) begin
      if (end_frame) begin
        row_nxt        = '0;
        col_nxt        = '0;
        write_bank_nxt = ~write_bank_r;
        prev_ready_nxt = 1'b1;
      end else if (end_row) begin
        row_nxt = row_r + fmf_pkg::ROW_W'(1);
        col_nxt = '0;
      end else begin
        col_nxt = col_r + fmf_pkg::COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= fmf_pkg::RST_FRAME_WIDTH;
      frame_height_r <= fmf_pkg::RST_FRAME_HEIGHT;
      mirror_mode_r  <= fmf_pkg::RST_MIRROR_MODE;
      write_bank_r   <= 1'b0;
      prev_ready_r   <= 1'b0;
      row_r          <= '0;
      col_r          <= '0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          fmf_pkg::CFG_FRAME_WIDTH:  frame_width_r  <= cfg_data;
          fmf_pkg::CFG_FRAME_HEIGHT: frame_height_r <= cfg_data;
          fmf_pkg::CFG_MIRROR_MODE:  mirror_mode_r  <= cfg_data[0];
          default: ;
        endcase
      end
      write_bank_r <= write_bank_nxt;
      prev_ready_r <= prev_ready_nxt;
      row_r        <= row_nxt;
      col_r        <= col_nxt;
    end
  end

  a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= w_last)
    else $error("column counter ran past the row end");

  a_row_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    row_r <= h_last)
    else $error("row counter ran past the frame end");

  a_bank_flip: assert property (@(posedge clk) disable iff (!rst_n)
    accept && end_frame && !cfg_hit |=> prev_ready_r && (write_bank_r != $past(write_bank_r)))
    else $error("bank did not swap at the end of a frame");

endmodule
`default_nettype wire

// ----- hw/rtl/fmf_store.sv -----
`default_nettype none
module fmf_store (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire fmf_pkg::fmf_req_t req,
  output logic                   ready,
  fmf_out_if.source              out_stream
);

  logic [fmf_pkg::PIX_W-1:0] mem [fmf_pkg::DEPTH];

  logic [fmf_pkg::PIX_W-1:0] rd_data_r;
  logic                      rd_valid_r;
  logic                      rd_row_last_r;
  logic                      rd_frame_last_r;

  logic                      out_valid_r;
  logic [fmf_pkg::PIX_W-1:0] out_pixel_r;
  logic                      out_row_last_r;
  logic                      out_frame_last_r;

  logic                      advance;

  // The read stage moves on when the output register is free or drains now.
  assign advance = !out_valid_r || out_stream.ready;
  assign ready   = !rd_valid_r || advance;

  // Reads and writes of one cycle always fall in opposite banks.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_row_last_r   <= req.row_last;
      rd_frame_last_r <= req.frame_last;
    end
    if (advance && rd_valid_r) begin
      out_pixel_r      <= rd_data_r;
      out_row_last_r   <= rd_row_last_r;
      out_frame_last_r <= rd_frame_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ready) begin
        rd_valid_r <= req.rd_en;
      end
      if (advance) begin
        out_valid_r <= rd_valid_r;
      end
    end
  end

  assign out_stream.valid      = out_valid_r;
  assign out_stream.pixel_out  = out_pixel_r;
  assign out_stream.row_last   = out_row_last_r;
  assign out_stream.frame_last = out_frame_last_r;

  a_read_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
    req.rd_en |-> ready && req.wr_en)
    else $error("store read issued without an input transfer");

  a_banks_apart: assert property (@(posedge clk) disable iff (!rst_n)
    req.rd_en |-> (req.rd_addr[fmf_pkg::ADDR_W-1] != req.wr_addr[fmf_pkg::ADDR_W-1]))
    else $error("read and write hit the same bank");

  a_read_stage_held: assert property (@(posedge clk) disable iff (!rst_n)
    rd_valid_r && !advance |=> rd_valid_r)
    else $error("stalled read stage lost its pixel");

endmodule
`default_nettype wire
